FILE: design/ihd_pkg.sv
// Shared types, constants and the IUPAC decode function for the handle demultiplexer.
package ihd_pkg;

  // Fixed field widths
  localparam int unsigned BASE_W      = 8;
  localparam int unsigned MATE_LEN_W  = 10;
  localparam int unsigned FRAG_W      = 32;
  localparam int unsigned CHOSEN_W    = 2;
  localparam int unsigned TRIM_W      = 5;
  localparam int unsigned READ_LEN_W  = 10;
  localparam int unsigned SET_W       = 4;
  localparam int unsigned LEN_FIELD_W = 5;
  localparam int unsigned LENGTHS_W   = 20;
  localparam int unsigned IN_USE_W    = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ZERO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LENGTHS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASKS_IN_USE = 3'd5;
  localparam logic [IN_USE_W-1:0]  IN_USE_RESET     = 3'd1;

  // Nucleotide set bits
  localparam logic [SET_W-1:0] SET_A = 4'b0001;
  localparam logic [SET_W-1:0] SET_C = 4'b0010;
  localparam logic [SET_W-1:0] SET_G = 4'b0100;
  localparam logic [SET_W-1:0] SET_T = 4'b1000;

  // Both reads must exceed the mask length by more than this
  localparam logic [LEN_FIELD_W-1:0] LENGTH_MARGIN = 5'd4;

  // Defaults for the top-level parameters
  localparam int unsigned MASK_SLOTS_DEF      = 4;
  localparam int unsigned MASK_POSITIONS_DEF  = 16;
  localparam int unsigned MAX_READ_LENGTH_DEF = 1023;

  typedef struct packed {
    logic [BASE_W-1:0]     base_char;
    logic                  last_base;
    logic [MATE_LEN_W-1:0] mate_length;
  } in_item_t;

  typedef struct packed {
    logic [FRAG_W-1:0]     fragment_number;
    logic                  keep;
    logic [CHOSEN_W-1:0]   chosen_mask;
    logic [TRIM_W-1:0]     trim_length;
    logic [READ_LEN_W-1:0] read_length;
  } out_item_t;

  // IUPAC character to nucleotide set; zero for anything not an upper-case code
  function automatic logic [SET_W-1:0] base_set(input logic [BASE_W-1:0] ch);
    logic [SET_W-1:0] s;
    case (ch)
      8'h41:        s = SET_A;                  // A
      8'h43:        s = SET_C;                  // C
      8'h47:        s = SET_G;                  // G
      8'h54, 8'h55: s = SET_T;                  // T, U
      8'h52:        s = SET_A | SET_G;          // R
      8'h59:        s = SET_C | SET_T;          // Y
      8'h53:        s = SET_G | SET_C;          // S
      8'h57:        s = SET_A | SET_T;          // W
      8'h4B:        s = SET_G | SET_T;          // K
      8'h4D:        s = SET_A | SET_C;          // M
      8'h42:        s = SET_C | SET_G | SET_T;  // B
      8'h44:        s = SET_A | SET_G | SET_T;  // D
      8'h48:        s = SET_A | SET_C | SET_T;  // H
      8'h56:        s = SET_A | SET_C | SET_G;  // V
      8'h4E:        s = SET_A | SET_C | SET_G | SET_T; // N
      default:      s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/iupac_handle_demultiplexer_top.sv
// Flow: an item is registered at the input, then matched against all masks
// combinationally; a last base's result enters the result register once that is free.
// Throughput: one base per cycle unless a last base waits on the result register; set by
// the single match stage that owns the per-read state (alive masks, position, fragment count).
// Reset: asynchronous, active low; clears valids, position and fragment count, revives
// all masks, sets mask codes and lengths to zero and masks in use to one.
module iupac_handle_demultiplexer_top #(
  parameter int unsigned MASK_SLOTS      = ihd_pkg::MASK_SLOTS_DEF,
  parameter int unsigned MASK_POSITIONS  = ihd_pkg::MASK_POSITIONS_DEF,
  parameter int unsigned MAX_READ_LENGTH = ihd_pkg::MAX_READ_LENGTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ihd_pkg::in_item_t                in_item_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ihd_pkg::out_item_t               out_item_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [ihd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ihd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned CodesW = ihd_pkg::SET_W * MASK_POSITIONS;
  localparam int unsigned CntW   = $clog2(MAX_READ_LENGTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_READ_LENGTH);
  localparam logic [ihd_pkg::LEN_FIELD_W-1:0] PosMax =
    ihd_pkg::LEN_FIELD_W'(MASK_POSITIONS);

  // Configuration registers
  logic [MASK_SLOTS-1:0][CodesW-1:0]      codes_q;
  logic [ihd_pkg::LENGTHS_W-1:0]          lengths_q;
  logic [ihd_pkg::IN_USE_W-1:0]           in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q   <= '0;
      lengths_q <= '0;
      in_use_q  <= ihd_pkg::IN_USE_RESET;
    end else if (cfg_we_i) begin
      for (int s = 0; s < MASK_SLOTS; s++) begin
        if (cfg_index_i == ihd_pkg::REG_MASK_ZERO + ihd_pkg::CFG_IDX_W'(s)) begin
          codes_q[s] <= cfg_data_i[CodesW-1:0];
        end
      end
      if (cfg_index_i == ihd_pkg::REG_MASK_LENGTHS) begin
        lengths_q <= cfg_data_i[ihd_pkg::LENGTHS_W-1:0];
      end
      if (cfg_index_i == ihd_pkg::REG_MASKS_IN_USE) begin
        in_use_q <= cfg_data_i[ihd_pkg::IN_USE_W-1:0];
      end
    end
  end

  // Clamped mask lengths
  logic [MASK_SLOTS-1:0][ihd_pkg::LEN_FIELD_W-1:0] len_clamped;

  always_comb begin
    for (int m = 0; m < MASK_SLOTS; m++) begin
      len_clamped[m] = lengths_q[ihd_pkg::LEN_FIELD_W*m +: ihd_pkg::LEN_FIELD_W];
      if (len_clamped[m] > PosMax) begin
        len_clamped[m] = PosMax;
      end
    end
  end

  // Handshake control
  logic stage_valid_q;
  logic out_valid_q;
  logic out_free;
  logic stage_fire;
  ihd_pkg::in_item_t stage_item_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign stage_fire = stage_valid_q && (!stage_item_q.last_base || out_free);
  assign in_ready_o = !stage_valid_q || stage_fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_item_q <= in_item_i;
    end
  end

  // Per-read state
  logic [MASK_SLOTS-1:0] alive_q, alive_d;
  logic [CntW-1:0]       pos_q, count;
  logic [ihd_pkg::FRAG_W-1:0] frag_q, frag_next;

  // Match one base against every mask at the current position
  logic [ihd_pkg::SET_W-1:0] set;

  always_comb begin
    logic [ihd_pkg::SET_W-1:0] code;
    set     = ihd_pkg::base_set(stage_item_q.base_char);
    alive_d = alive_q;
    for (int m = 0; m < MASK_SLOTS; m++) begin
      code = '0;
      for (int p = 0; p < MASK_POSITIONS; p++) begin
        if (pos_q == CntW'(p)) begin
          code = codes_q[m][ihd_pkg::SET_W*p +: ihd_pkg::SET_W];
        end
      end
      if (pos_q < CntW'(len_clamped[m]) && ((code & set) == '0)) begin
        alive_d[m] = 1'b0;
      end
    end
  end

  assign count     = (pos_q < CntMax) ? pos_q + CntW'(1) : CntMax;
  assign frag_next = frag_q + ihd_pkg::FRAG_W'(1);

  // First surviving mask among those in use, then the length test
  ihd_pkg::out_item_t result;

  always_comb begin
    logic                              found;
    logic [ihd_pkg::CHOSEN_W-1:0]      chosen;
    logic [ihd_pkg::LEN_FIELD_W-1:0]   len;
    logic [ihd_pkg::LEN_FIELD_W-1:0]   need;
    found  = 1'b0;
    chosen = '0;
    len    = '0;
    for (int m = MASK_SLOTS - 1; m >= 0; m--) begin
      if (alive_d[m] && (ihd_pkg::IN_USE_W'(m) < in_use_q)) begin
        found  = 1'b1;
        chosen = ihd_pkg::CHOSEN_W'(m);
        len    = len_clamped[m];
      end
    end
    need = len + ihd_pkg::LENGTH_MARGIN;
    result.fragment_number = frag_next;
    result.keep = found && (count > CntW'(need))
                  && (stage_item_q.mate_length > ihd_pkg::MATE_LEN_W'(need));
    result.chosen_mask = result.keep ? chosen : '0;
    result.trim_length = result.keep ? len : '0;
    result.read_length = ihd_pkg::READ_LEN_W'(count);
  end

  // State update: last base resets position, revives all masks and advances the fragment count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
      pos_q   <= '0;
      frag_q  <= '0;
    end else if (stage_fire) begin
      if (stage_item_q.last_base) begin
        alive_q <= '1;
        pos_q   <= '0;
        frag_q  <= frag_next;
      end else begin
        alive_q <= alive_d;
        pos_q   <= count;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= stage_fire && stage_item_q.last_base;
    end
  end

  ihd_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i) begin
    if (out_free && stage_fire && stage_item_q.last_base) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: verif/iupac_handle_demultiplexer_tb.sv
// Self-checking testbench for the IUPAC handle demultiplexer: streams reads, predicts fragments.
module testbench;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_BASES   = 58;
  localparam int DRAIN_CYCLES  = 8;
  localparam logic [127:0] IUPAC_CODES = "ACGTURYSWKMBDHVN";

  typedef enum logic [1:0] {READ_MATCH, READ_VALID, READ_NOISE, READ_SHORT} read_kind_e;

  logic                           clk_i     = 1'b0;
  logic                           rst_ni    = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  ihd_pkg::in_item_t              in_item   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ihd_pkg::out_item_t             out_item;
  logic                           cfg_we    = 1'b0;
  logic [ihd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ihd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor copy of the registers and the per-read state
  logic [ihd_pkg::CFG_DATA_W-1:0] mask_codes [4];
  logic [ihd_pkg::LENGTHS_W-1:0]  mask_lens;
  logic [ihd_pkg::IN_USE_W-1:0]   in_use;
  logic [3:0]                     alive;
  int                             base_pos;
  logic [ihd_pkg::FRAG_W-1:0]     frag_count;

  ihd_pkg::in_item_t  pending_bases[$];
  ihd_pkg::out_item_t expected_results[$];

  int   cycle = 0;
  int   error_count = 0;
  int   bases_queued = 0;
  int   results_seen = 0;
  int   kept_seen = 0;
  int   settings_run = 0;
  logic steady;

  // Stretch with no idling on either side
  assign steady = (cycle >= 300) && (cycle < 650);

  iupac_handle_demultiplexer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Upper-case IUPAC letter to nucleotide set, zero when not a code
  function automatic logic [ihd_pkg::SET_W-1:0] iupac_to_set(logic [ihd_pkg::BASE_W-1:0] ch);
    case (ch)
      "A":      return ihd_pkg::SET_A;
      "C":      return ihd_pkg::SET_C;
      "G":      return ihd_pkg::SET_G;
      "T", "U": return ihd_pkg::SET_T;
      "R":      return ihd_pkg::SET_A | ihd_pkg::SET_G;
      "Y":      return ihd_pkg::SET_C | ihd_pkg::SET_T;
      "S":      return ihd_pkg::SET_C | ihd_pkg::SET_G;
      "W":      return ihd_pkg::SET_A | ihd_pkg::SET_T;
      "K":      return ihd_pkg::SET_G | ihd_pkg::SET_T;
      "M":      return ihd_pkg::SET_A | ihd_pkg::SET_C;
      "B":      return ihd_pkg::SET_C | ihd_pkg::SET_G | ihd_pkg::SET_T;
      "D":      return ihd_pkg::SET_A | ihd_pkg::SET_G | ihd_pkg::SET_T;
      "H":      return ihd_pkg::SET_A | ihd_pkg::SET_C | ihd_pkg::SET_T;
      "V":      return ihd_pkg::SET_A | ihd_pkg::SET_C | ihd_pkg::SET_G;
      "N":      return ihd_pkg::SET_A | ihd_pkg::SET_C | ihd_pkg::SET_G | ihd_pkg::SET_T;
      default:  return '0;
    endcase
  endfunction

  // Positions in use of one mask, clamped to the mask depth
  function automatic int mask_len(int m);
    int len;
    len = int'(mask_lens[ihd_pkg::LEN_FIELD_W*m +: ihd_pkg::LEN_FIELD_W]);
    return (len > ihd_pkg::MASK_POSITIONS_DEF) ? ihd_pkg::MASK_POSITIONS_DEF : len;
  endfunction

  function automatic void reset_predictor();
    for (int m = 0; m < 4; m++) mask_codes[m] = '0;
    mask_lens  = '0;
    in_use     = ihd_pkg::IN_USE_RESET;
    alive      = '1;
    base_pos   = 0;
    frag_count = '0;
  endfunction

  // Advance the read state by one base; a last base yields one fragment result
  task automatic predict_base(ihd_pkg::in_item_t it);
    logic [ihd_pkg::SET_W-1:0] nuc_set;
    logic [ihd_pkg::SET_W-1:0] code;
    int                        count, used, chosen, len;
    logic                      found, keep;
    ihd_pkg::out_item_t        res;
    nuc_set = iupac_to_set(it.base_char);
    for (int m = 0; m < ihd_pkg::MASK_SLOTS_DEF; m++) begin
      if (base_pos < mask_len(m)) begin
        code = mask_codes[m][4*base_pos +: 4];
        if (nuc_set == '0 || (code & nuc_set) == '0) alive[m] = 1'b0;
      end
    end
    count = (base_pos < ihd_pkg::MAX_READ_LENGTH_DEF) ? base_pos + 1 :
                                                        ihd_pkg::MAX_READ_LENGTH_DEF;
    base_pos = count;
    if (it.last_base) begin
      frag_count++;
      used   = (in_use > ihd_pkg::MASK_SLOTS_DEF) ? ihd_pkg::MASK_SLOTS_DEF : int'(in_use);
      found  = 1'b0;
      keep   = 1'b0;
      chosen = 0;
      len    = 0;
      // lowest surviving mask wins
      for (int m = 0; m < used; m++) begin
        if (!found && alive[m]) begin
          found  = 1'b1;
          chosen = m;
        end
      end
      if (found) begin
        len  = mask_len(chosen);
        keep = (count > len + ihd_pkg::LENGTH_MARGIN) &&
               (it.mate_length > len + ihd_pkg::LENGTH_MARGIN);
      end
      res.fragment_number = frag_count;
      res.keep            = keep;
      res.chosen_mask     = keep ? chosen[ihd_pkg::CHOSEN_W-1:0] : '0;
      res.trim_length     = keep ? len[ihd_pkg::TRIM_W-1:0] : '0;
      res.read_length     = count[ihd_pkg::READ_LEN_W-1:0];
      expected_results = {expected_results, res};
      alive    = '1;
      base_pos = 0;
    end
  endtask

  task automatic report_error(string msg);
    error_count++;
    $display("[cycle %0d] mismatch: %s", cycle, msg);
  endtask

  task automatic check_result(ihd_pkg::out_item_t got);
    ihd_pkg::out_item_t want;
    results_seen++;
    if (got.keep === 1'b1) kept_seen++;
    if (expected_results.size() == 0) begin
      report_error($sformatf("unexpected result, fragment %0d", got.fragment_number));
      return;
    end
    want = expected_results.pop_front();
    if (got.fragment_number !== want.fragment_number)
      report_error($sformatf("fragment_number got %0d want %0d",
                             got.fragment_number, want.fragment_number));
    if (got.keep !== want.keep)
      report_error($sformatf("fragment %0d keep got %0b want %0b",
                             want.fragment_number, got.keep, want.keep));
    if (got.chosen_mask !== want.chosen_mask)
      report_error($sformatf("fragment %0d chosen_mask got %0d want %0d",
                             want.fragment_number, got.chosen_mask, want.chosen_mask));
    if (got.trim_length !== want.trim_length)
      report_error($sformatf("fragment %0d trim_length got %0d want %0d",
                             want.fragment_number, got.trim_length, want.trim_length));
    if (got.read_length !== want.read_length)
      report_error($sformatf("fragment %0d read_length got %0d want %0d",
                             want.fragment_number, got.read_length, want.read_length));
  endtask

  // Input driver: one item per handshake, random idle cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) predict_base(in_item);
      if (!in_valid || in_ready) begin
        if (pending_bases.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
          in_item  <= pending_bases.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      out_ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // Cycle count and timeout
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("iupac_handle_demultiplexer_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [ihd_pkg::CFG_IDX_W-1:0] idx,
                           logic [ihd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < ihd_pkg::REG_MASK_LENGTHS) mask_codes[idx] = val;
    else if (idx == ihd_pkg::REG_MASK_LENGTHS) mask_lens = val[ihd_pkg::LENGTHS_W-1:0];
    else if (idx == ihd_pkg::REG_MASKS_IN_USE) in_use = val[ihd_pkg::IN_USE_W-1:0];
  endtask

  task automatic apply_setting(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                               logic [63:0] c3, logic [ihd_pkg::LENGTHS_W-1:0] lens,
                               logic [ihd_pkg::IN_USE_W-1:0] used);
    write_reg(ihd_pkg::REG_MASK_ZERO, c0);
    write_reg(ihd_pkg::REG_MASK_ZERO + 3'd1, c1);
    write_reg(ihd_pkg::REG_MASK_ZERO + 3'd2, c2);
    write_reg(ihd_pkg::REG_MASK_ZERO + 3'd3, c3);
    write_reg(ihd_pkg::REG_MASK_LENGTHS, ihd_pkg::CFG_DATA_W'(lens));
    write_reg(ihd_pkg::REG_MASKS_IN_USE, ihd_pkg::CFG_DATA_W'(used));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mostly nonzero position sets, now and then fully random
  function automatic logic [63:0] random_codes();
    logic [63:0] c;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    for (int p = 0; p < 16; p++)
      c[4*p +: 4] = ($urandom_range(9) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
    return c;
  endfunction

  // Lengths mostly within the mask depth, some above it
  function automatic logic [ihd_pkg::LENGTHS_W-1:0] random_lengths();
    logic [ihd_pkg::LENGTHS_W-1:0] l;
    for (int m = 0; m < 4; m++)
      l[ihd_pkg::LEN_FIELD_W*m +: ihd_pkg::LEN_FIELD_W] = ($urandom_range(7) == 0) ?
          5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    return l;
  endfunction

  // A valid IUPAC letter whose set overlaps code; any letter when code is empty
  function automatic logic [ihd_pkg::BASE_W-1:0] pick_char(logic [ihd_pkg::SET_W-1:0] code);
    logic [ihd_pkg::BASE_W-1:0] ch;
    for (int k = 0; k < 8; k++) begin
      ch = IUPAC_CODES[8*$urandom_range(15) +: 8];
      if (code == '0 || (iupac_to_set(ch) & code) != '0) return ch;
    end
    return "N";
  endfunction

  task automatic queue_base(logic [ihd_pkg::BASE_W-1:0] ch, logic last,
                            logic [ihd_pkg::MATE_LEN_W-1:0] mate);
    ihd_pkg::in_item_t it;
    it.base_char   = ch;
    it.last_base   = last;
    it.mate_length = mate;
    pending_bases = {pending_bases, it};
    bases_queued++;
  endtask

  task automatic queue_text(string s, logic [ihd_pkg::MATE_LEN_W-1:0] mate);
    for (int i = 0; i < s.len(); i++)
      queue_base(s[i], i == s.len() - 1,
                 (i == s.len() - 1) ? mate : 10'($urandom_range(1023)));
  endtask

  // One whole read aimed at a random mask; fixed_len > 0 forces the length
  task automatic queue_read(read_kind_e kind, int fixed_len);
    int                             target, tlen, len, cut;
    logic [ihd_pkg::MATE_LEN_W-1:0] mate;
    logic [ihd_pkg::BASE_W-1:0]     ch;
    target = $urandom_range(3);
    tlen   = mask_len(target);
    case (kind)
      READ_MATCH: len = tlen + $urandom_range(3, 10);
      READ_SHORT: len = $urandom_range(1, (tlen > 1) ? tlen : 1);
      default:    len = $urandom_range(1, 24);
    endcase
    if (fixed_len > 0) len = fixed_len;
    // now and then a single corrupted base breaks the sequence
    cut = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : -1;
    case ($urandom_range(3))
      0:       mate = ihd_pkg::MATE_LEN_W'(tlen + 4);
      1:       mate = ihd_pkg::MATE_LEN_W'(tlen + 5);
      default: mate = ihd_pkg::MATE_LEN_W'($urandom_range(1023));
    endcase
    for (int i = 0; i < len; i++) begin
      if ((kind == READ_NOISE && $urandom_range(3) != 0) || i == cut)
        ch = ihd_pkg::BASE_W'($urandom_range(255));
      else if ((kind == READ_MATCH || kind == READ_SHORT) && i < tlen)
        ch = pick_char(mask_codes[target][4*i +: 4]);
      else
        ch = pick_char('0);
      queue_base(ch, i == len - 1, (i == len - 1) ? mate : 10'($urandom_range(1023)));
    end
  endtask

  // Wait until every item is taken and every result seen, then let the pipe settle
  task automatic wait_idle();
    while (pending_bases.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    int phase, phase_end, r;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: only mask 0 compared, with no positions
    queue_text("RYSKM", 10'd5);
    wait_idle();

    // mask 0 "AC", mask 1 "G", mask 2 over-long all-N, mask 3 empty
    apply_setting(64'h21, 64'h4, '1, '0, {5'd0, 5'd17, 5'd1, 5'd2}, 3'd4);
    queue_text("A", 10'd0);           // read shorter than the mask
    queue_text("GTTTTT", 10'd1023);   // mask 0 dies, mask 1 kept
    queue_text("aBDHV", 10'd5);       // lower case kills all but the empty mask
    queue_base(8'hFF, 1'b0, 10'd0);
    queue_base(8'h00, 1'b0, 10'h3FF);
    queue_text("UVW", 10'd4);         // mate exactly at the margin
    queue_text("ACNNNNN", 10'd7);     // mask 0 kept
    wait_idle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_setting('1, '1, '1, '1, {4{5'd16}}, 3'd4);
        1: apply_setting('0, '0, '0, '0, {4{5'd31}}, 3'd7);
        2: apply_setting(random_codes(), random_codes(), random_codes(), random_codes(),
                         random_lengths(), 3'd0);
        3: apply_setting(random_codes(), random_codes(), random_codes(), random_codes(),
                         '0, 3'd1);
        default: apply_setting(random_codes(), random_codes(), random_codes(),
                               random_codes(), random_lengths(),
                               ($urandom_range(3) == 0) ? 3'($urandom_range(7)) :
                                                          3'($urandom_range(1, 4)));
      endcase
      phase_end = bases_queued + PHASE_BASES;
      while (bases_queued < phase_end) begin
        r = $urandom_range(99);
        if (r < 60)      queue_read(READ_MATCH, 0);
        else if (r < 75) queue_read(READ_VALID, 0);
        else if (r < 87) queue_read(READ_NOISE, 0);
        else             queue_read(READ_SHORT, 0);
      end
      wait_idle();
    end

    $display("Checked %0d fragments (%0d kept) from %0d bases under %0d mask settings.",
             results_seen, kept_seen, bases_queued, settings_run);
    $display("Covered invalid bases, short reads, clamped lengths and 0 to 7 masks in use.");
    if (error_count == 0) begin
      $display("iupac_handle_demultiplexer_top verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("iupac_handle_demultiplexer_top verification failed");
    end
    $finish;
  end

endmodule

FILE: iupac_handle_demultiplexer_top.f
design/ihd_pkg.sv
design/iupac_handle_demultiplexer_top.sv
verif/iupac_handle_demultiplexer_tb.sv
